// ----- rtl/vcs_pkg.sv -----
package vcs_pkg;

   typedef enum logic [1:0] {
      OP_COMMAND  = 2'd0,
      OP_ODOM_FB  = 2'd1,
      OP_ROBOT_FB = 2'd2,
      OP_TICK     = 2'd3
   } opcode_type;

   localparam logic [2:0] CSR_SPEED_LIM_LIN = 3'd0;
   localparam logic [2:0] CSR_SPEED_LIM_ANG = 3'd1;
   localparam logic [2:0] CSR_ACCEL_LIN     = 3'd2;
   localparam logic [2:0] CSR_ACCEL_ANG     = 3'd3;
   localparam logic [2:0] CSR_DECEL_FACTOR  = 3'd4;
   localparam logic [2:0] CSR_FB_MODE       = 3'd5;

   localparam logic [1:0] FB_NONE  = 2'd0;
   localparam logic [1:0] FB_ODOM  = 2'd1;
   localparam logic [1:0] FB_ROBOT = 2'd2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int VEL_W      = 16;
   localparam int TIME_W     = 32;
   localparam int LIM_W      = 15;
   localparam int DECF_W     = 12;
   localparam int MAG_W      = 16;
   localparam int STEP_W     = 27;
   localparam int PROD_W     = STEP_W + MAG_W;
   localparam int DIV_NW     = PROD_W - 8;
   localparam int DIV_STEPS  = DIV_NW;

   localparam logic [TIME_W-1:0] DEFAULT_PERIOD_US = 32'd100000;
   localparam logic [33:0]       TIMEOUT_CAP_US    = 34'd500000;
   localparam logic [DECF_W-1:0] DECEL_RESET       = 12'd256;

endpackage

// ----- rtl/vcs_channels.sv -----
interface vcs_req_if;
   import vcs_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic signed [VEL_W-1:0] lin_vel;
   logic signed [VEL_W-1:0] ang_vel;
   logic [TIME_W-1:0] time_us;
   modport source (output valid, opcode, lin_vel, ang_vel, time_us, input ready);
   modport sink   (input valid, opcode, lin_vel, ang_vel, time_us, output ready);
endinterface

interface vcs_rsp_if;
   import vcs_pkg::*;
   logic              valid;
   logic              ready;
   logic signed [VEL_W-1:0] lin_cmd;
   logic signed [VEL_W-1:0] ang_cmd;
   logic              used_feedback;
   logic              timed_out;
   modport source (output valid, lin_cmd, ang_cmd, used_feedback, timed_out, input ready);
   modport sink   (input valid, lin_cmd, ang_cmd, used_feedback, timed_out, output ready);
endinterface

interface vcs_csr_if;
   import vcs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/velocity_command_smoother_unit.sv -----
// Two-axis velocity command smoother with acceleration-limited ramp.
// req_ch takes words: command (clamped, becomes the target, arrival time
// feeds the period ring), odometry or robot feedback (updates the measured
// velocity when the feedback mode matches) and control tick.
// rsp_ch gives one word per tick, except a tick that finds the output at
// the target with input inactive, which gives none.
// csr_ch writes the six limit and mode registers; write only while idle.
// Work per word: feedback is stored when taken; a command writes the ring
// and, once the ring holds more than half its entries, runs the rank
// search over the ring memory (one read and one compare per pass); a tick
// runs the shared multiplier and, where needed, the 35-step serial
// divider. One word is in work at a time; req_ch.ready is low until it
// finishes. A finished result sits in the output register; a stalled
// receiver only holds a tick at its final step; words before it are taken,
// none after. Reset clears control state and configuration (deceleration
// ratio to 1.0) but not the datapath registers; the period ring needs no
// clearing pass since only written entries are read.
module velocity_command_smoother_unit #(
   parameter int PERIOD_RING_SIZE = 5
) (
   input  logic  clock,
   input  logic  reset,
   vcs_req_if.sink   req_ch,
   vcs_rsp_if.source rsp_ch,
   vcs_csr_if.sink   csr_ch
);
   import vcs_pkg::*;

   localparam int RW = $clog2(PERIOD_RING_SIZE);
   localparam int CW = $clog2(PERIOD_RING_SIZE + 1);
   localparam logic [CW-1:0] RING_FULL = CW'(PERIOD_RING_SIZE);
   localparam logic [CW-1:0] RING_HALF = CW'(PERIOD_RING_SIZE / 2);
   localparam logic [RW-1:0] RING_LAST = RW'(PERIOD_RING_SIZE - 1);

   typedef enum logic [16:0] {
      S_IDLE  = 17'h00001,
      S_CMD   = 17'h00002,
      S_MRDI  = 17'h00004,
      S_MXI   = 17'h00008,
      S_MRDJ  = 17'h00010,
      S_MCMP  = 17'h00020,
      S_MCHK  = 17'h00040,
      S_TO    = 17'h00080,
      S_DECA  = 17'h00100,
      S_FB    = 17'h00200,
      S_DIFF  = 17'h00400,
      S_P1    = 17'h00800,
      S_P2    = 17'h01000,
      S_CMP   = 17'h02000,
      S_DIV   = 17'h04000,
      S_APPLY = 17'h08000,
      S_OUT   = 17'h10000
   } state_type;

   // configuration
   logic [LIM_W-1:0]  spd_lin_ff, spd_ang_ff, acc_lin_ff, acc_ang_ff;
   logic [DECF_W-1:0] decf_ff;
   logic [1:0]        fbm_ff;

   state_type state_ff, state_in;

   logic signed [VEL_W-1:0] lv_ff, av_ff;
   logic [TIME_W-1:0]       t_ff;

   logic signed [VEL_W-1:0] tgt_lin_ff, tgt_ang_ff, out_lin_ff, out_ang_ff;
   logic signed [VEL_W-1:0] meas_lin_ff, meas_ang_ff;
   logic                    active_ff;
   logic [TIME_W-1:0]       arrival_ff, avg_ff, elapsed_ff;
   logic [CW-1:0]           count_ff, n_ff, lt_ff, le_ff;
   logic [RW-1:0]           next_ff, i_ff, j_ff;
   logic [TIME_W-1:0]       x_ff;

   logic [TIME_W-1:0] ring [PERIOD_RING_SIZE];
   logic [TIME_W-1:0] rd_data_ff;
   logic [RW-1:0]     rd_addr;
   logic              ring_we;

   logic [STEP_W-1:0] dec_l_ff, dec_a_ff, mv_ff, mw_ff;
   logic [MAG_W-1:0]  adv_ff, adw_ff;
   logic              dv_neg_ff, dw_neg_ff, lim_lin_ff;
   logic [PROD_W-1:0] prod_ff, p1_ff;
   logic [STEP_W-1:0] mul_a;
   logic [MAG_W-1:0]  mul_b;
   logic [DIV_NW-1:0] sv_ff, sw_ff;
   logic              used_ff, timed_ff;

   logic                    rsp_valid_ff;
   logic signed [VEL_W-1:0] rsp_lin_ff, rsp_ang_ff;
   logic                    rsp_used_ff, rsp_timed_ff;

   logic              div_start, div_done;
   logic [DIV_NW-1:0] div_num, div_q;
   logic [MAG_W-1:0]  div_den;

   logic              req_take;
   logic [CW-1:0]     n_new;
   logic [TIME_W-1:0] elapsed_now;
   logic [33:0]       thr3, thr;
   logic [34:0]       thr5;
   logic [STEP_W-1:0] acc_l, acc_a;
   logic              dev_lin, dev_ang;
   logic signed [VEL_W:0] dv, dw;
   logic              out_load;

   function automatic logic signed [VEL_W-1:0] clamp_mag(
      input logic signed [VEL_W-1:0] v,
      input logic [LIM_W-1:0]        lim
   );
      logic signed [VEL_W-1:0] l;
      l = signed'({1'b0, lim});
      if (v > 0) clamp_mag = (v > l) ? l : v;
      else       clamp_mag = (v < -l) ? -l : v;
   endfunction

   function automatic logic deviates(
      input logic signed [VEL_W-1:0] meas,
      input logic signed [VEL_W-1:0] last,
      input logic [STEP_W-1:0]       acc,
      input logic [STEP_W-1:0]       dec
   );
      logic signed [VEL_W:0]  d;
      logic signed [29:0]     s;
      d = (VEL_W+1)'(meas) - (VEL_W+1)'(last);
      s = 30'(d) <<< 8;
      deviates = (s + signed'({2'b0, dec, 1'b0}) < 0) ||
                 (s > signed'({2'b0, acc, 1'b0}));
   endfunction

   function automatic logic [STEP_W-1:0] axis_limit(
      input logic signed [VEL_W:0]   inc,
      input logic signed [VEL_W-1:0] tgt,
      input logic signed [VEL_W-1:0] meas,
      input logic [1:0]              mode,
      input logic [STEP_W-1:0]       acc,
      input logic [STEP_W-1:0]       dec
   );
      priority if (mode == FB_ODOM && ((meas > 0 && tgt < 0) || (meas < 0 && tgt > 0)))
         axis_limit = dec;
      else if ((inc > 0 && tgt > 0) || (inc < 0 && tgt < 0))
         axis_limit = acc;
      else
         axis_limit = dec;
   endfunction

   function automatic logic [MAG_W-1:0] mag17(input logic signed [VEL_W:0] v);
      logic signed [VEL_W:0] a;
      a = (v < 0) ? -v : v;
      mag17 = a[MAG_W-1:0];
   endfunction

   function automatic logic signed [VEL_W-1:0] step_axis(
      input logic signed [VEL_W-1:0] last,
      input logic signed [VEL_W-1:0] tgt,
      input logic                    neg,
      input logic [MAG_W-1:0]        mag,
      input logic [DIV_NW-1:0]       step
   );
      if ({{(DIV_NW-MAG_W){1'b0}}, mag} > step)
         step_axis = neg ? last - signed'(step[VEL_W-1:0])
                         : last + signed'(step[VEL_W-1:0]);
      else
         step_axis = tgt;
   endfunction

   assign req_take      = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE);
   assign csr_ch.ready  = 1'b1;

   assign elapsed_now = t_ff - arrival_ff;
   assign n_new       = (count_ff == RING_FULL) ? RING_FULL : count_ff + 1'b1;
   assign thr3        = {2'b0, avg_ff} + {1'b0, avg_ff, 1'b0};
   assign thr         = (thr3 > TIMEOUT_CAP_US) ? TIMEOUT_CAP_US : thr3;
   assign thr5        = {3'b0, avg_ff} + {1'b0, avg_ff, 2'b0};
   assign acc_l       = {4'b0, acc_lin_ff, 8'b0};
   assign acc_a       = {4'b0, acc_ang_ff, 8'b0};
   assign dev_lin     = deviates(meas_lin_ff, out_lin_ff, acc_l, dec_l_ff);
   assign dev_ang     = deviates(meas_ang_ff, out_ang_ff, acc_a, prod_ff[STEP_W-1:0]);
   assign dv          = (VEL_W+1)'(tgt_lin_ff) - (VEL_W+1)'(out_lin_ff);
   assign dw          = (VEL_W+1)'(tgt_ang_ff) - (VEL_W+1)'(out_ang_ff);
   assign out_load    = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);
   assign ring_we     = (state_ff == S_CMD);
   assign rd_addr     = (state_ff == S_MRDJ) ? j_ff : i_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = mw_ff;
      mul_b = adv_ff;
      unique case (state_ff)
         S_TO:    begin mul_a = STEP_W'(acc_lin_ff); mul_b = MAG_W'(decf_ff); end
         S_DECA:  begin mul_a = STEP_W'(acc_ang_ff); mul_b = MAG_W'(decf_ff); end
         S_P2:    begin mul_a = mv_ff; mul_b = adw_ff; end
         default: begin mul_a = mw_ff; mul_b = adv_ff; end
      endcase
   end

   // divider launch
   always_comb begin
      div_start = 1'b0;
      div_num   = prod_ff[PROD_W-1:8];
      div_den   = adv_ff;
      if (state_ff == S_CMP) begin
         if (p1_ff < prod_ff) begin
            div_start = 1'b1;
            div_num   = p1_ff[PROD_W-1:8];
            div_den   = adw_ff;
         end else if (adv_ff != '0) begin
            div_start = 1'b1;
         end
      end
   end

   vcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_take) begin
            priority if (req_ch.opcode == OP_COMMAND) state_in = S_CMD;
            else if (req_ch.opcode == OP_TICK)        state_in = S_TO;
            else                                      state_in = S_IDLE;
         end
         S_CMD:   state_in = (n_new <= RING_HALF) ? S_IDLE : S_MRDI;
         S_MRDI:  state_in = S_MXI;
         S_MXI:   state_in = S_MRDJ;
         S_MRDJ:  state_in = S_MCMP;
         S_MCMP:  state_in = (CW'(j_ff) == n_ff - 1'b1) ? S_MCHK : S_MRDJ;
         S_MCHK:  state_in = (lt_ff <= (n_ff >> 1) && le_ff > (n_ff >> 1)) ? S_IDLE : S_MRDI;
         S_TO:    state_in = S_DECA;
         S_DECA:  state_in = S_FB;
         S_FB:    state_in = S_DIFF;
         S_DIFF: begin
            if (dv != 0 || dw != 0) state_in = S_P1;
            else if (active_ff)     state_in = S_OUT;
            else                    state_in = S_IDLE;
         end
         S_P1:    state_in = S_P2;
         S_P2:    state_in = S_CMP;
         S_CMP:   state_in = div_start ? S_DIV : S_APPLY;
         S_DIV:   state_in = div_done ? S_APPLY : S_DIV;
         S_APPLY: state_in = S_OUT;
         S_OUT:   state_in = out_load ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   // period ring memory
   always_ff @(posedge clock) begin
      if (ring_we) ring[next_ff] <= elapsed_now;
      rd_data_ff <= ring[rd_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         spd_lin_ff   <= '0;
         spd_ang_ff   <= '0;
         acc_lin_ff   <= '0;
         acc_ang_ff   <= '0;
         decf_ff      <= DECEL_RESET;
         fbm_ff       <= FB_NONE;
         tgt_lin_ff   <= '0;
         tgt_ang_ff   <= '0;
         out_lin_ff   <= '0;
         out_ang_ff   <= '0;
         meas_lin_ff  <= '0;
         meas_ang_ff  <= '0;
         active_ff    <= 1'b0;
         arrival_ff   <= '0;
         avg_ff       <= '0;
         count_ff     <= '0;
         next_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_SPEED_LIM_LIN: spd_lin_ff <= csr_ch.data[LIM_W-1:0];
               CSR_SPEED_LIM_ANG: spd_ang_ff <= csr_ch.data[LIM_W-1:0];
               CSR_ACCEL_LIN:     acc_lin_ff <= csr_ch.data[LIM_W-1:0];
               CSR_ACCEL_ANG:     acc_ang_ff <= csr_ch.data[LIM_W-1:0];
               CSR_DECEL_FACTOR:  decf_ff    <= csr_ch.data[DECF_W-1:0];
               CSR_FB_MODE:       fbm_ff     <= csr_ch.data[1:0];
               default: ;
            endcase
         end
         if (req_take && (req_ch.opcode == OP_ODOM_FB || req_ch.opcode == OP_ROBOT_FB)
             && fbm_ff == req_ch.opcode) begin
            meas_lin_ff <= req_ch.lin_vel;
            meas_ang_ff <= req_ch.ang_vel;
         end
         if (out_load)          rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CMD: begin
               next_ff    <= (next_ff == RING_LAST) ? '0 : next_ff + 1'b1;
               count_ff   <= n_new;
               arrival_ff <= t_ff;
               active_ff  <= 1'b1;
               tgt_lin_ff <= clamp_mag(lv_ff, spd_lin_ff);
               tgt_ang_ff <= clamp_mag(av_ff, spd_ang_ff);
               if (n_new <= RING_HALF) avg_ff <= DEFAULT_PERIOD_US;
            end
            S_MCHK: if (lt_ff <= (n_ff >> 1) && le_ff > (n_ff >> 1)) avg_ff <= x_ff;
            S_TO: begin
               if (active_ff && avg_ff != '0 && {2'b0, elapsed_now} > thr) begin
                  active_ff  <= 1'b0;
                  tgt_lin_ff <= '0;
                  tgt_ang_ff <= '0;
               end
            end
            S_FB: begin
               if ((fbm_ff == FB_ODOM || fbm_ff == FB_ROBOT) && active_ff && avg_ff != '0
                   && ({3'b0, elapsed_ff} > thr5 || dev_lin || dev_ang)) begin
                  out_lin_ff <= meas_lin_ff;
                  out_ang_ff <= meas_ang_ff;
               end
            end
            S_APPLY: begin
               out_lin_ff <= step_axis(out_lin_ff, tgt_lin_ff, dv_neg_ff, adv_ff, sv_ff);
               out_ang_ff <= step_axis(out_ang_ff, tgt_ang_ff, dw_neg_ff, adw_ff, sw_ff);
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         lv_ff <= req_ch.lin_vel;
         av_ff <= req_ch.ang_vel;
         t_ff  <= req_ch.time_us;
      end
      if (out_load) begin
         rsp_lin_ff   <= out_lin_ff;
         rsp_ang_ff   <= out_ang_ff;
         rsp_used_ff  <= used_ff;
         rsp_timed_ff <= timed_ff;
      end
      unique case (state_ff)
         S_CMD: begin
            n_ff <= n_new;
            i_ff <= '0;
         end
         S_MXI: begin
            x_ff  <= rd_data_ff;
            j_ff  <= '0;
            lt_ff <= '0;
            le_ff <= '0;
         end
         S_MCMP: begin
            if (rd_data_ff < x_ff)  lt_ff <= lt_ff + 1'b1;
            if (rd_data_ff <= x_ff) le_ff <= le_ff + 1'b1;
            j_ff <= j_ff + 1'b1;
         end
         S_MCHK: i_ff <= i_ff + 1'b1;
         S_TO: begin
            elapsed_ff <= elapsed_now;
            used_ff    <= 1'b0;
            timed_ff   <= active_ff && avg_ff != '0 && {2'b0, elapsed_now} > thr;
         end
         S_DECA: dec_l_ff <= prod_ff[STEP_W-1:0];
         S_FB: begin
            dec_a_ff <= prod_ff[STEP_W-1:0];
            used_ff  <= (fbm_ff == FB_ODOM || fbm_ff == FB_ROBOT) && active_ff
                        && avg_ff != '0 && ({3'b0, elapsed_ff} > thr5 || dev_lin || dev_ang);
         end
         S_DIFF: begin
            mv_ff     <= axis_limit(dv, tgt_lin_ff, meas_lin_ff, fbm_ff, acc_l, dec_l_ff);
            mw_ff     <= axis_limit(dw, tgt_ang_ff, meas_ang_ff, fbm_ff, acc_a, dec_a_ff);
            adv_ff    <= mag17(dv);
            adw_ff    <= mag17(dw);
            dv_neg_ff <= dv < 0;
            dw_neg_ff <= dw < 0;
         end
         S_P2: p1_ff <= prod_ff;
         S_CMP: begin
            lim_lin_ff <= p1_ff < prod_ff;
            if (p1_ff < prod_ff) begin
               sw_ff <= DIV_NW'(mw_ff >> 8);
            end else begin
               sv_ff <= DIV_NW'(mv_ff >> 8);
               if (adv_ff == '0) sw_ff <= DIV_NW'(mw_ff >> 8);
            end
         end
         S_DIV: if (div_done) begin
            if (lim_lin_ff) sv_ff <= div_q;
            else            sw_ff <= div_q;
         end
         default: ;
      endcase
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.lin_cmd       = rsp_lin_ff;
   assign rsp_ch.ang_cmd       = rsp_ang_ff;
   assign rsp_ch.used_feedback = rsp_used_ff;
   assign rsp_ch.timed_out     = rsp_timed_ff;

endmodule

// ----- rtl/vcs_div.sv -----
module vcs_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vcs_pkg::DIV_NW-1:0]  dividend,
   input  logic [vcs_pkg::MAG_W-1:0]   divisor,
   output logic                        done,
   output logic [vcs_pkg::DIV_NW-1:0]  quotient
);
   import vcs_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  den_ff, den_in;
   logic [DIV_NW-1:0] dq_ff, dq_in;
   logic [MAG_W:0]    trial;
   logic              fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, dq_ff[DIV_NW-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dq_in   = dq_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         dq_in   = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? MAG_W'(trial - {1'b0, den_ff}) : trial[MAG_W-1:0];
         dq_in  = {dq_ff[DIV_NW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      dq_ff  <= dq_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

// ----- test/velocity_command_smoother_unit_tb.sv -----
module velocity_command_smoother_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vcs_pkg::*;

   localparam int RING_DEPTH = 5;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic signed [VEL_W-1:0] lin;
      logic signed [VEL_W-1:0] ang;
      logic                    fb;
      logic                    to;
   } smoothed_word_type;

   class smoother_scoreboard_type;
      int spd_lin, spd_ang, step_lin, step_ang, decel_q8;
      logic [1:0] fb_mode;
      int tgt_lin, tgt_ang, out_lin, out_ang, meas_lin, meas_ang;
      bit active;
      logic [TIME_W-1:0] last_arrival, avg_period;
      logic [TIME_W-1:0] periods[RING_DEPTH];
      int fill, wr_ptr;
      smoothed_word_type expected_words[$];
      int errors;

      function void clear();
         spd_lin = 0; spd_ang = 0; step_lin = 0; step_ang = 0;
         decel_q8 = int'(DECEL_RESET); fb_mode = FB_NONE;
         tgt_lin = 0; tgt_ang = 0; out_lin = 0; out_ang = 0;
         meas_lin = 0; meas_ang = 0; active = 0;
         last_arrival = 0; avg_period = 0; fill = 0; wr_ptr = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            CSR_SPEED_LIM_LIN: spd_lin = int'(d[LIM_W-1:0]);
            CSR_SPEED_LIM_ANG: spd_ang = int'(d[LIM_W-1:0]);
            CSR_ACCEL_LIN:     step_lin = int'(d[LIM_W-1:0]);
            CSR_ACCEL_ANG:     step_ang = int'(d[LIM_W-1:0]);
            CSR_DECEL_FACTOR:  decel_q8 = int'(d[DECF_W-1:0]);
            CSR_FB_MODE:       fb_mode = d[1:0];
            default: ;
         endcase
      endfunction

      function int clamp_mag(int v, int lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function longint median_period();
         longint s[RING_DEPTH];
         longint x;
         int j;
         for (int i = 0; i < fill; i++) begin
            x = periods[i];
            j = i;
            while (j > 0 && s[j-1] > x) begin
               s[j] = s[j-1];
               j--;
            end
            s[j] = x;
         end
         return s[fill/2];
      endfunction

      function bit off_track(int meas, int last, longint acc, longint dec);
         longint m, c;
         m = longint'(meas) * 256;
         c = longint'(last) * 256;
         return m < c - 2*dec || m > c + 2*acc;
      endfunction

      function longint axis_rate(int inc, int tgt, int meas, longint acc, longint dec);
         if (fb_mode == FB_ODOM && ((meas > 0 && tgt < 0) || (meas < 0 && tgt > 0)))
            return dec;
         if ((inc > 0 && tgt > 0) || (inc < 0 && tgt < 0)) return acc;
         return dec;
      endfunction

      function int step_toward(int last, int tgt, int inc, longint stp);
         longint mag;
         mag = inc < 0 ? -longint'(inc) : longint'(inc);
         if (mag > stp) return inc < 0 ? last - int'(stp) : last + int'(stp);
         return tgt;
      endfunction

      function void note_word(opcode_type op, logic signed [VEL_W-1:0] lv,
                              logic signed [VEL_W-1:0] av, logic [TIME_W-1:0] t);
         logic [TIME_W-1:0] elapsed;
         longint thr, acc_l, acc_a, dec_l, dec_a, mv, mw, adv, adw, sv, sw;
         int dv, dw;
         bit timed, used;
         smoothed_word_type w;
         timed = 0;
         used = 0;
         if (op == OP_COMMAND) begin
            periods[wr_ptr] = t - last_arrival;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            if (fill < RING_DEPTH) fill++;
            last_arrival = t;
            avg_period = (fill <= RING_DEPTH/2) ? DEFAULT_PERIOD_US
                                                : TIME_W'(median_period());
            active = 1;
            tgt_lin = clamp_mag(int'(lv), spd_lin);
            tgt_ang = clamp_mag(int'(av), spd_ang);
            return;
         end
         if (op != OP_TICK) begin
            if (fb_mode == op) begin
               meas_lin = int'(lv);
               meas_ang = int'(av);
            end
            return;
         end
         elapsed = t - last_arrival;
         thr = 3 * longint'(avg_period);
         if (thr > 500000) thr = 500000;
         if (active && avg_period != 0 && longint'(elapsed) > thr) begin
            active = 0;
            tgt_lin = 0;
            tgt_ang = 0;
            timed = 1;
         end
         acc_l = longint'(step_lin) * 256;
         acc_a = longint'(step_ang) * 256;
         dec_l = longint'(step_lin) * decel_q8;
         dec_a = longint'(step_ang) * decel_q8;
         if ((fb_mode == FB_ODOM || fb_mode == FB_ROBOT) && active && avg_period != 0 &&
             (longint'(elapsed) > 5 * longint'(avg_period) ||
              off_track(meas_lin, out_lin, acc_l, dec_l) ||
              off_track(meas_ang, out_ang, acc_a, dec_a))) begin
            out_lin = meas_lin;
            out_ang = meas_ang;
            used = 1;
         end
         if (tgt_lin != out_lin || tgt_ang != out_ang) begin
            dv = tgt_lin - out_lin;
            dw = tgt_ang - out_ang;
            mv = axis_rate(dv, tgt_lin, meas_lin, acc_l, dec_l);
            mw = axis_rate(dw, tgt_ang, meas_ang, acc_a, dec_a);
            adv = dv < 0 ? -longint'(dv) : longint'(dv);
            adw = dw < 0 ? -longint'(dw) : longint'(dw);
            // keep the direction of the change: the tighter axis sets the pace
            if (mw * adv < mv * adw) begin
               sv = (mw * adv) / (adw * 256);
               sw = mw / 256;
            end else begin
               sv = mv / 256;
               sw = adv != 0 ? (mv * adw) / (adv * 256) : mw / 256;
            end
            out_lin = step_toward(out_lin, tgt_lin, dv, sv);
            out_ang = step_toward(out_ang, tgt_ang, dw, sw);
         end else if (!active) begin
            return;
         end
         w.lin = out_lin[VEL_W-1:0];
         w.ang = out_ang[VEL_W-1:0];
         w.fb = used;
         w.to = timed;
         expected_words = {expected_words, w};
      endfunction

      function void check(logic signed [VEL_W-1:0] lin, logic signed [VEL_W-1:0] ang,
                          logic fb, logic to);
         smoothed_word_type w;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word lin %0d ang %0d", $time, lin, ang);
            errors++;
            return;
         end
         w = expected_words.pop_front();
         if (lin !== w.lin) begin
            $display("%0t: lin_cmd expected %0d got %0d", $time, w.lin, lin);
            errors++;
         end
         if (ang !== w.ang) begin
            $display("%0t: ang_cmd expected %0d got %0d", $time, w.ang, ang);
            errors++;
         end
         if (fb !== w.fb) begin
            $display("%0t: used_feedback expected %0d got %0d", $time, w.fb, fb);
            errors++;
         end
         if (to !== w.to) begin
            $display("%0t: timed_out expected %0d got %0d", $time, w.to, to);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   vcs_req_if req ();
   vcs_rsp_if rsp ();
   vcs_csr_if csr ();

   velocity_command_smoother_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   smoother_scoreboard_type sb = new();
   int tx_idle_pct;
   int rx_idle_pct;
   int quiet_cycles;
   logic [TIME_W-1:0] now_us;
   int period_us;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp.ready <= !reset && ($urandom_range(99) >= rx_idle_pct);
      if (!reset && rsp.valid && rsp.ready)
         sb.check(rsp.lin_cmd, rsp.ang_cmd, rsp.used_feedback, rsp.timed_out);
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_word(opcode_type op, logic signed [VEL_W-1:0] lv,
                            logic signed [VEL_W-1:0] av, logic [TIME_W-1:0] t);
      while ($urandom_range(99) < tx_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.opcode <= op;
      req.lin_vel <= lv;
      req.ang_vel <= av;
      req.time_us <= t;
      do @(posedge clock); while (!req.ready);
      sb.note_word(op, lv, av, t);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr.valid <= 1;
      csr.index <= idx;
      csr.data <= d;
      do @(posedge clock); while (!csr.ready);
      sb.write_reg(idx, d);
      csr.valid <= 0;
      @(posedge clock);
   endtask

   // hold until every word is back, then let a silent tick finish
   task automatic drain();
      req.valid <= 0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic setup(int sl, int sa, int al, int aa, int df, logic [1:0] mode);
      write_csr(CSR_SPEED_LIM_LIN, CSR_DATA_W'(sl));
      write_csr(CSR_SPEED_LIM_ANG, CSR_DATA_W'(sa));
      write_csr(CSR_ACCEL_LIN, CSR_DATA_W'(al));
      write_csr(CSR_ACCEL_ANG, CSR_DATA_W'(aa));
      write_csr(CSR_DECEL_FACTOR, CSR_DATA_W'(df));
      write_csr(CSR_FB_MODE, CSR_DATA_W'(mode));
   endtask

   function automatic logic signed [VEL_W-1:0] pick_vel(int lim, int near);
      case ($urandom_range(3))
         0: return VEL_W'($urandom);
         1: return VEL_W'(near + $signed($urandom_range(600)) - 300);
         default: return VEL_W'($signed($urandom_range(2*lim + 2)) - lim - 1);
      endcase
   endfunction

   task automatic random_word();
      int r;
      opcode_type op;
      r = $urandom_range(99);
      if (r < 30) begin
         now_us += period_us/2 + $urandom_range(period_us);
         send_word(OP_COMMAND, pick_vel(sb.spd_lin, sb.out_lin),
                   pick_vel(sb.spd_ang, sb.out_ang), now_us);
      end else if (r < 48) begin
         op = $urandom_range(1) ? OP_ODOM_FB : OP_ROBOT_FB;
         send_word(op, pick_vel(sb.spd_lin, sb.out_lin),
                   pick_vel(sb.spd_ang, sb.out_ang), $urandom);
      end else begin
         if ($urandom_range(99) < 6)
            now_us += $urandom_range(200000, 900000);
         else
            now_us += $urandom_range(period_us/3);
         send_word(OP_TICK, VEL_W'($urandom), VEL_W'($urandom), now_us);
      end
   endtask

   initial begin
      int sl, sa;
      reset = 1;
      req.valid <= 0;
      req.opcode <= OP_COMMAND;
      req.lin_vel <= '0;
      req.ang_vel <= '0;
      req.time_us <= '0;
      csr.valid <= 0;
      csr.index <= CSR_SPEED_LIM_LIN;
      csr.data <= '0;
      tx_idle_pct = 8;
      rx_idle_pct = 60;
      quiet_cycles = 0;
      sb.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every opcode, timeout, fallback, ring fill past half
      setup(20000, 15000, 700, 400, 384, FB_ODOM);
      now_us = 32'hFFFF_0000;
      send_word(OP_TICK, '0, '0, now_us);
      send_word(OP_COMMAND, 16'sh7FFF, -16'sh8000, now_us);
      send_word(OP_TICK, '0, '0, now_us + 1000);
      send_word(OP_ODOM_FB, -16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF);
      send_word(OP_TICK, 16'sh7FFF, -16'sd1, now_us + 2000);
      send_word(OP_ROBOT_FB, 16'sd1234, -16'sd1234, '0);
      send_word(OP_ODOM_FB, '0, '0, '0);
      for (int i = 0; i < 4; i++) begin
         now_us += 50000;
         send_word(OP_COMMAND, -16'sh8000, 16'sh7FFF, now_us);
         send_word(OP_TICK, '0, '0, now_us + 100);
      end
      send_word(OP_ODOM_FB, 16'sd5000, -16'sd5000, '0);
      send_word(OP_TICK, '0, '0, now_us + 200);
      now_us += 400000;
      send_word(OP_TICK, '0, '0, now_us);
      now_us += 2000000;
      send_word(OP_TICK, '0, '0, now_us);
      send_word(OP_TICK, '0, '0, now_us + 10);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         tx_idle_pct = ph < 2 ? 8 : (ph < 4 ? 60 : 0);
         rx_idle_pct = ph < 2 ? 60 : (ph < 4 ? 8 : 0);
         sl = $urandom_range(32767);
         sa = $urandom_range(32767);
         case (ph)
            0: setup(32767, 32767, 32767, 32767, 4095, FB_NONE);
            1: setup(0, 0, 0, 0, 0, FB_ROBOT);
            2: setup(sl, sa, $urandom_range(2000), $urandom_range(2000),
                     $urandom_range(4095), FB_ODOM);
            3: setup(sl, sa, $urandom_range(32767), $urandom_range(32767),
                     $urandom_range(4095), 2'd3);
            4: setup(sl, sa, $urandom_range(300), $urandom_range(300),
                     256, FB_ROBOT);
            default: setup(sl, sa, $urandom_range(5000), $urandom_range(5000),
                           $urandom_range(4095), FB_ODOM);
         endcase
         period_us = $urandom_range(20000, 150000);
         repeat (150) random_word();
         drain();
      end

      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (sb.expected_words.size() != 0)
            $display("%0t: %0d expected words never arrived", $time,
                     sb.expected_words.size());
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ----- files.f -----
rtl/vcs_pkg.sv
rtl/vcs_channels.sv
rtl/vcs_div.sv
rtl/velocity_command_smoother_unit.sv
test/velocity_command_smoother_unit_tb.sv
